FILE: hw/rtl/h264rtp_pkg.sv
// h264rtp_pkg: shared types and constants of the h264 rtp packetizer
// transfer structs, register map, offset widths and fu-a header constants
// no dependencies
package h264rtp_pkg;

	localparam int UNIT_BYTES_MAX = 1048576;
	localparam int OFS_W          = $clog2(UNIT_BYTES_MAX + 1);
	localparam logic [OFS_W-1:0] UNIT_LIMIT = OFS_W'(UNIT_BYTES_MAX);

	localparam int OFFSET_W = 20;
	localparam int LEN_W    = 11;
	localparam int SEQ_W    = 16;
	localparam int TS_W     = 32;

	localparam int NUM_REGS = 4;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = $clog2(NUM_REGS * 4);

	localparam logic [LEN_W-1:0] MTU_MIN      = 11'd3;
	localparam logic [LEN_W-1:0] MTU_MAX      = 11'd1488;
	localparam logic [LEN_W-1:0] MTU_RESET    = 11'd1200;
	localparam logic [31:0]      TS_STEP_RESET = 32'd3000;
	localparam logic [31:0]      SSRC_RESET   = 32'd1234;
	localparam logic [6:0]       PT_RESET     = 7'd96;

	localparam logic [23:0] RECENT_RESET   = 24'hFFFFFF;
	localparam logic [7:0]  FU_NRI_MASK    = 8'hE0;
	localparam logic [7:0]  FU_A_TYPE      = 8'd28;
	localparam logic [7:0]  NAL_TYPE_MASK  = 8'h1F;
	localparam logic [7:0]  FU_S_BIT       = 8'h80;
	localparam logic [7:0]  FU_E_BIT       = 8'h40;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		REG_MAX_PAYLOAD,
		REG_TS_STEP,
		REG_SSRC,
		REG_PT
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_unit;
	} in_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0]    sequence_number;
		logic [TS_W-1:0]     rtp_time;
		logic                marker_bit;
		logic                is_fragment;
		logic [7:0]          fu_indicator_byte;
		logic [7:0]          fu_header_byte;
		logic [OFFSET_W-1:0] payload_offset;
		logic [LEN_W-1:0]    payload_length;
		logic                last_of_run;
	} desc_t;

	typedef struct packed {
		logic [LEN_W-1:0] max_packet_payload;
		logic [31:0]      timestamp_step;
	} cfg_t;

	typedef struct packed {
		logic [1:0] n;
		desc_t      d0;
		desc_t      d1;
	} push_t;

endpackage

FILE: hw/rtl/h264rtp_cfg.sv
// h264rtp_cfg: apb register file of the packetizer
// holds mtu, timestamp step, ssrc and payload type; uses h264rtp_pkg
module h264rtp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [h264rtp_pkg::PADDR_W-1:0] paddr,
	input  logic [h264rtp_pkg::DATA_W-1:0]  pwdata,
	output logic [h264rtp_pkg::DATA_W-1:0]  prdata,
	output logic                            pready,
	output h264rtp_pkg::cfg_t               cfg
);
	import h264rtp_pkg::*;

	logic [LEN_W-1:0] mpp_q;
	logic [31:0]      ts_step_q;
	logic [31:0]      ssrc_q;
	logic [6:0]       pt_q;
	reg_idx_t         idx;
	logic             wr;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpp_q     <= MTU_RESET;
			ts_step_q <= TS_STEP_RESET;
			ssrc_q    <= SSRC_RESET;
			pt_q      <= PT_RESET;
		end else if (wr) begin
			case (idx)
				REG_MAX_PAYLOAD: mpp_q     <= pwdata[LEN_W-1:0];
				REG_TS_STEP:     ts_step_q <= pwdata[31:0];
				REG_SSRC:        ssrc_q    <= pwdata[31:0];
				REG_PT:          pt_q      <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_PAYLOAD: prdata = DATA_W'(mpp_q);
			REG_TS_STEP:     prdata = DATA_W'(ts_step_q);
			REG_SSRC:        prdata = DATA_W'(ssrc_q);
			REG_PT:          prdata = DATA_W'(pt_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.max_packet_payload = mpp_q;
	assign cfg.timestamp_step     = ts_step_q;

endmodule

FILE: hw/rtl/h264rtp_core.sv
// h264rtp_core: input register, start code scan and descriptor generation
// keeps nal and fragment state, emits up to two descriptors per byte; uses h264rtp_pkg
module h264rtp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  h264rtp_pkg::cfg_t     cfg,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  h264rtp_pkg::in_item_t byte_data,
	input  logic                  room,
	output h264rtp_pkg::push_t    push
);
	import h264rtp_pkg::*;

	localparam int W1 = OFS_W + 1;

	function automatic desc_t build_desc(
		input logic [SEQ_W-1:0] seq,
		input logic [TS_W-1:0]  ts,
		input logic             frag,
		input logic             s,
		input logic             e,
		input logic [7:0]       hdr,
		input logic [W1-1:0]    off,
		input logic [OFS_W-1:0] len,
		input logic             last
	);
		desc_t d;
		d.sequence_number   = seq;
		d.rtp_time          = ts;
		d.marker_bit        = !frag || e;
		d.is_fragment       = frag;
		d.fu_indicator_byte = frag ? ((hdr & FU_NRI_MASK) | FU_A_TYPE) : 8'h00;
		d.fu_header_byte    = frag ? ((s ? FU_S_BIT : 8'h00) | (e ? FU_E_BIT : 8'h00)
			| (hdr & NAL_TYPE_MASK)) : 8'h00;
		d.payload_offset    = OFFSET_W'(off);
		d.payload_length    = LEN_W'(len);
		d.last_of_run       = last;
		return d;
	endfunction

	logic             valid_s1;
	in_item_t         item_s1;

	logic [OFS_W-1:0] unit_ofs_q;
	logic [23:0]      recent_q;
	logic             inside_q;
	logic [OFS_W-1:0] start_q;
	logic [7:0]       hdr_q;
	logic [OFS_W-1:0] fno_q;
	logic             first_q;
	logic [SEQ_W-1:0] seq_q;
	logic [TS_W-1:0]  ts_q;

	logic             go;
	logic [LEN_W-1:0] mtu;
	logic [LEN_W-1:0] chunk;
	logic [7:0]       byte_v;
	logic             last;
	logic             accepted;
	logic             code;
	logic             at_hdr;
	logic [7:0]       hdr;
	logic [W1-1:0]    frag_base;
	logic [OFS_W-1:0] end_ofs;
	logic [OFS_W-1:0] size;
	logic [OFS_W-1:0] rem;
	logic             single;
	logic             split;
	logic             close;
	logic             step_frag;
	logic [1:0]       n;
	desc_t            d0;
	desc_t            d1;

	assign go         = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_data;
		end
	end

	always_comb begin
		mtu = cfg.max_packet_payload;
		if (cfg.max_packet_payload < MTU_MIN) begin
			mtu = MTU_MIN;
		end else if (cfg.max_packet_payload > MTU_MAX) begin
			mtu = MTU_MAX;
		end
		chunk    = mtu - LEN_W'(2);
		byte_v   = item_s1.data_byte;
		last     = item_s1.last_of_unit;
		accepted = unit_ofs_q < UNIT_LIMIT;
		code     = accepted && (recent_q == 24'h000000) && (byte_v == 8'h01);
		at_hdr   = accepted && inside_q && (unit_ofs_q == start_q);
		hdr      = at_hdr ? byte_v : hdr_q;
		frag_base = first_q ? (W1'(start_q) + W1'(1)) : W1'(fno_q);

		if (code) begin
			end_ofs = unit_ofs_q - OFS_W'(3);
		end else if (accepted) begin
			end_ofs = unit_ofs_q + OFS_W'(1);
		end else begin
			end_ofs = unit_ofs_q;
		end

		size   = end_ofs - start_q;
		rem    = (W1'(end_ofs) > frag_base) ? OFS_W'(W1'(end_ofs) - frag_base) : '0;
		single = first_q && (size < OFS_W'(mtu));
		split  = !single && (rem > OFS_W'(chunk));
		close  = inside_q && (code || last);
		step_frag = !code && inside_q && !last && accepted
			&& (W1'(unit_ofs_q) >= W1'(start_q) + W1'(2))
			&& (W1'(unit_ofs_q) >= frag_base + W1'(chunk) + W1'(3));

		n  = 2'd0;
		d0 = '0;
		d1 = '0;
		if (close) begin
			if (single) begin
				d0 = build_desc(seq_q, ts_q, 1'b0, 1'b0, 1'b0, hdr, W1'(start_q), size, 1'b1);
				n  = 2'd1;
			end else if (split) begin
				d0 = build_desc(seq_q, ts_q, 1'b1, first_q, 1'b0, hdr, frag_base,
					OFS_W'(chunk), 1'b0);
				d1 = build_desc(seq_q + SEQ_W'(1), ts_q, 1'b1, 1'b0, 1'b1, hdr,
					frag_base + W1'(chunk), rem - OFS_W'(chunk), 1'b1);
				n  = 2'd2;
			end else begin
				d0 = build_desc(seq_q, ts_q, 1'b1, first_q, 1'b1, hdr, frag_base, rem, 1'b1);
				n  = 2'd1;
			end
		end else if (step_frag) begin
			d0 = build_desc(seq_q, ts_q, 1'b1, first_q, 1'b0, hdr, frag_base,
				OFS_W'(chunk), 1'b1);
			n  = 2'd1;
		end
	end

	assign push.n  = go ? n : 2'd0;
	assign push.d0 = d0;
	assign push.d1 = d1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ofs_q <= '0;
			recent_q   <= RECENT_RESET;
			inside_q   <= 1'b0;
			start_q    <= '0;
			hdr_q      <= '0;
			fno_q      <= '0;
			first_q    <= 1'b1;
			seq_q      <= '0;
			ts_q       <= '0;
		end else if (go) begin
			if (accepted) begin
				recent_q   <= code ? RECENT_RESET : {recent_q[15:0], byte_v};
				unit_ofs_q <= unit_ofs_q + OFS_W'(1);
				if (at_hdr) begin
					hdr_q <= byte_v;
				end
			end
			if (code) begin
				inside_q <= 1'b1;
				start_q  <= unit_ofs_q + OFS_W'(1);
				first_q  <= 1'b1;
			end
			if (step_frag) begin
				first_q <= 1'b0;
				fno_q   <= OFS_W'(frag_base + W1'(chunk));
			end
			seq_q <= seq_q + SEQ_W'(n);
			// end of access unit overrides the offset, window, nal and first-fragment updates above
			if (last) begin
				unit_ofs_q <= '0;
				recent_q   <= RECENT_RESET;
				inside_q   <= 1'b0;
				first_q    <= 1'b1;
				ts_q       <= ts_q + cfg.timestamp_step;
			end
		end
	end

endmodule

FILE: hw/rtl/h264rtp_outq.sv
// h264rtp_outq: small descriptor queue between generator and output channel
// takes up to two descriptors per cycle, gives one per transfer; uses h264rtp_pkg
module h264rtp_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  h264rtp_pkg::push_t push,
	output logic               room,
	output logic               desc_valid,
	input  logic               desc_stall,
	output h264rtp_pkg::desc_t desc
);
	import h264rtp_pkg::*;

	desc_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               pop;

	assign desc_valid = cnt_q != '0;
	assign desc       = mem_q[rd_ptr_q];
	assign pop        = desc_valid && !desc_stall;
	assign room       = cnt_q <= Q_CNT_W'(Q_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.d0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + Q_PTR_W'(1)] <= push.d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
		end
	end

endmodule

FILE: hw/rtl/h264rtp_packetizer_top.sv
// h264_rtp_packetizer_top: rtp / fu-a descriptor generator for annex b streams
// instantiates h264rtp_cfg, h264rtp_core and h264rtp_outq; uses h264rtp_pkg
//
// usage:
//   byte channel (byte_valid/byte_stall/byte_data): one access unit byte per
//   transfer, last_of_unit on the final byte of the unit.
//   desc channel (desc_valid/desc_stall/desc): rtp packet descriptors for a dma
//   engine, in sequence number order; last_of_run flags the last descriptor
//   caused by one byte. descriptors trail the data by up to four bytes.
//   apb port: max_packet_payload 0x0, timestamp_step 0x4, stream_source_id
//   0x8, payload_type 0xc; write only while no descriptors are pending.
// path: a byte is held in the input register, its descriptors are written
//   into a four entry queue, and desc shows the queue head combinationally.
// throughput: one byte per cycle unless byte_stall; a byte closing a long nal
//   yields two descriptors and the one-per-cycle queue output sets the rate.
// stall: the queue absorbs the output stall; once it holds more than two
//   entries byte_stall rises until the receiver takes descriptors again.
// reset: registers return to their defaults, state and queue are empty, the
//   sequence number and timestamp restart at zero.
module h264_rtp_packetizer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [h264rtp_pkg::PADDR_W-1:0] paddr,
	input  logic [h264rtp_pkg::DATA_W-1:0]  pwdata,
	output logic [h264rtp_pkg::DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  h264rtp_pkg::in_item_t           byte_data,
	output logic                            desc_valid,
	input  logic                            desc_stall,
	output h264rtp_pkg::desc_t              desc
);
	import h264rtp_pkg::*;

	cfg_t  cfg;
	push_t push;
	logic  room;

	h264rtp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	h264rtp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.room       (room),
		.push       (push)
	);

	h264rtp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.desc_valid (desc_valid),
		.desc_stall (desc_stall),
		.desc       (desc)
	);

	// second descriptor of a run is already queued and is the final fragment
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid && !desc_stall && !desc.last_of_run
		|=> desc_valid && desc.is_fragment && desc.marker_bit)
		else $error("second descriptor of a run missing or not a final fragment");

	a_seq_consecutive: assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid && !desc_stall ##1 desc_valid
		|-> desc.sequence_number == $past(desc.sequence_number) + 16'd1)
		else $error("sequence number not consecutive across transfers");

	a_single_alone: assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid && !desc.is_fragment
		|-> desc.marker_bit && desc.last_of_run && desc.fu_header_byte == 8'h00)
		else $error("unfragmented descriptor malformed");

endmodule

FILE: tb/h264_rtp_packetizer_top_tb.sv
// h264_rtp_packetizer_top_tb: self-checking bench for the rtp / fu-a descriptor generator
// drives annex b units over the byte channel and checks every descriptor against a predictor
// depends on h264rtp_pkg and h264_rtp_packetizer_top
module h264_rtp_packetizer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import h264rtp_pkg::*;

	localparam int RANDOM_ITEMS   = 1450;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MTU_PICKS [8]  = '{0, 2047, 3, 1488, 4, 1489, 2, 5};

	typedef logic [7:0] byte_q_t [$];

	class fu_a_tracker;
		logic [LEN_W-1:0] mtu_reg;
		logic [31:0]      ts_step;
		logic [31:0]      ssrc;
		logic [6:0]       ptype;
		int unsigned      unit_ofs;
		logic [23:0]      recent;
		bit               in_nal;
		int unsigned      nal_start;
		logic [7:0]       nal_hdr;
		int unsigned      frag_next;
		bit               first_frag;
		logic [15:0]      seq;
		logic [31:0]      ts;
		desc_t            step_descs [$];
		desc_t            due_descs [$];
		int               failures;

		function new();
			mtu_reg = MTU_RESET;
			ts_step = TS_STEP_RESET;
			ssrc = SSRC_RESET;
			ptype = PT_RESET;
			unit_ofs = 0;
			recent = RECENT_RESET;
			in_nal = 0;
			nal_start = 0;
			nal_hdr = '0;
			frag_next = 0;
			first_frag = 1;
			seq = '0;
			ts = '0;
			failures = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_MAX_PAYLOAD: mtu_reg = val[LEN_W-1:0];
				REG_TS_STEP: ts_step = val;
				REG_SSRC: ssrc = val;
				REG_PT: ptype = val[6:0];
				default: ;
			endcase
		endfunction

		function int unsigned mtu_used();
			if (mtu_reg < MTU_MIN) return MTU_MIN;
			if (mtu_reg > MTU_MAX) return MTU_MAX;
			return mtu_reg;
		endfunction

		function void push_desc(bit frag, bit s, bit e, int unsigned ofs, int unsigned len);
			desc_t d;
			d.sequence_number = seq;
			d.rtp_time = ts;
			d.marker_bit = !(frag && !e);
			d.is_fragment = frag;
			d.fu_indicator_byte = frag ? ((nal_hdr & FU_NRI_MASK) | FU_A_TYPE) : 8'h00;
			d.fu_header_byte = frag ? ((s ? FU_S_BIT : 8'h00) | (e ? FU_E_BIT : 8'h00) |
				(nal_hdr & NAL_TYPE_MASK)) : 8'h00;
			d.payload_offset = OFFSET_W'(ofs);
			d.payload_length = LEN_W'(len);
			d.last_of_run = 1'b0;
			seq = seq + 16'd1;
			step_descs.push_back(d);
		endfunction

		function void flush_nal(int unsigned stop_ofs);
			int unsigned m, chunk, size, f, rem;
			m = mtu_used();
			chunk = m - 2;
			size = stop_ofs - nal_start;
			if (first_frag && size < m) begin
				push_desc(0, 0, 0, nal_start, size);
				return;
			end
			f = first_frag ? nal_start + 1 : frag_next;
			rem = (stop_ofs > f) ? stop_ofs - f : 0;
			if (rem > chunk) begin
				push_desc(1, first_frag, 0, f, chunk);
				first_frag = 0;
				f += chunk;
				rem -= chunk;
			end
			push_desc(1, first_frag, 1, f, rem);
			first_frag = 0;
			frag_next = f + rem;
		endfunction

		function void take_byte(in_item_t it);
			int unsigned cur, chunk, f;
			bit taken, code;
			logic [31:0] window;
			cur = unit_ofs;
			taken = cur < UNIT_BYTES_MAX;
			code = 0;
			step_descs.delete();
			if (taken) begin
				window = {recent, it.data_byte};
				code = (window == 32'h0000_0001);
				if (in_nal && cur == nal_start)
					nal_hdr = it.data_byte;
				recent = code ? RECENT_RESET : window[23:0];
				unit_ofs = cur + 1;
			end
			if (code) begin
				if (in_nal)
					flush_nal(cur - 3);
				if (!it.last_of_unit) begin
					in_nal = 1;
					nal_start = cur + 1;
					first_frag = 1;
				end else begin
					in_nal = 0;
				end
			end else if (in_nal) begin
				if (it.last_of_unit) begin
					flush_nal(unit_ofs);
				end else if (taken && cur >= nal_start + 2) begin
					chunk = mtu_used() - 2;
					f = first_frag ? nal_start + 1 : frag_next;
					if (cur - 2 >= f + chunk + 1) begin
						push_desc(1, first_frag, 0, f, chunk);
						first_frag = 0;
						frag_next = f + chunk;
					end
				end
			end
			if (it.last_of_unit) begin
				unit_ofs = 0;
				recent = RECENT_RESET;
				in_nal = 0;
				first_frag = 1;
				ts = ts + ts_step;
			end
			if (step_descs.size() > 0)
				step_descs[step_descs.size() - 1].last_of_run = 1'b1;
			foreach (step_descs[i])
				due_descs.push_back(step_descs[i]);
		endfunction

		function string desc_str(desc_t d);
			return $sformatf("seq=%0d ts=%0d m=%0b frag=%0b fui=%02h fuh=%02h ofs=%0d len=%0d lor=%0b",
				d.sequence_number, d.rtp_time, d.marker_bit, d.is_fragment,
				d.fu_indicator_byte, d.fu_header_byte, d.payload_offset,
				d.payload_length, d.last_of_run);
		endfunction

		function void check_desc(desc_t got);
			desc_t want;
			if (due_descs.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected descriptor: %s", desc_str(got));
				return;
			end
			want = due_descs.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("descriptor mismatch\n  exp %s\n  got %s", desc_str(want),
						desc_str(got));
			end
		endfunction

		function int pending();
			return due_descs.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               byte_valid = 1'b0;
	logic               byte_stall;
	in_item_t           byte_data = '0;
	logic               desc_valid;
	logic               desc_stall = 1'b0;
	desc_t              desc;

	fu_a_tracker sb = new();
	int  n_sent = 0;
	int  base_cnt = 0;
	bit  quiet = 0;
	bit  calm = 0;
	int  stall_left = 0;
	int  idle_cycles = 0;

	h264_rtp_packetizer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.desc_valid(desc_valid),
		.desc_stall(desc_stall),
		.desc(desc)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// descriptor receiver with random stall bursts
	always @(posedge clk) begin
		if (arst_n && desc_valid === 1'b1 && !desc_stall)
			sb.check_desc(desc);
		if (stall_left > 0)
			stall_left--;
		else if (!quiet && !calm && $urandom_range(0, 11) == 0)
			stall_left = $urandom_range(1, 17);
		desc_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		if ((byte_valid && byte_stall === 1'b0) || (desc_valid === 1'b1 && !desc_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		in_item_t it;
		it = '{data_byte: b, last_of_unit: lst};
		if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= it;
		do @(posedge clk); while (byte_stall !== 1'b0);
		sb.take_byte(it);
		n_sent++;
	endtask

	task automatic send_bytes(input byte_q_t q, input bit close_unit);
		foreach (q[i])
			send_byte(q[i], close_unit && i == q.size() - 1);
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [7:0] body_byte();
		return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
	endfunction

	function automatic void push_code(ref byte_q_t q);
		q.push_back(8'h00);
		q.push_back(8'h00);
		q.push_back(8'h00);
		q.push_back(8'h01);
	endfunction

	task automatic send_random_unit(input int unsigned eff, input bit close_unit);
		byte_q_t q;
		int nals, blen;
		calm = (n_sent - base_cnt) >= RANDOM_ITEMS * 4 / 5;
		if (close_unit && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) q.push_back(body_byte());
			send_bytes(q, 1);
			return;
		end
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
		nals = close_unit ? $urandom_range(1, 4) : 1;
		repeat (nals) begin
			push_code(q);
			if ($urandom_range(0, 9) != 0) begin
				q.push_back(8'($urandom));
				blen = $urandom_range(0, (eff <= 24) ? 3 * eff : 48);
				repeat (blen) q.push_back(body_byte());
			end
		end
		if (close_unit && $urandom_range(0, 7) == 0)
			push_code(q);
		send_bytes(q, close_unit);
	endtask

	initial begin
		int phase;
		int pick;
		int unsigned mtu_val;
		logic [31:0] step_val;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte, short nal, empty nal, trailing byte
		send_bytes('{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'hFF,
			8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41}, 1);
		// start code on the final bytes of the unit
		send_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'h00, 8'h00, 8'h00, 8'h01}, 1);

		base_cnt = n_sent;
		phase = 0;
		while (n_sent - base_cnt < RANDOM_ITEMS) begin
			drain();
			mtu_val = (phase < 8) ? MTU_PICKS[phase] :
				(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(3, 24));
			reg_write(REG_MAX_PAYLOAD, mtu_val);
			if (phase == 0 || $urandom_range(0, 1) == 0) begin
				pick = $urandom_range(0, 3);
				step_val = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
					(pick == 2) ? 32'($urandom) : TS_STEP_RESET;
				reg_write(REG_TS_STEP, step_val);
			end
			if (phase == 0 || $urandom_range(0, 1) == 0)
				reg_write(REG_SSRC, (phase == 0) ? 32'hFFFF_FFFF : 32'($urandom));
			if (phase == 0 || $urandom_range(0, 1) == 0)
				reg_write(REG_PT, (phase == 0) ? 32'd127 : 32'($urandom_range(0, 127)));
			quiet = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6))
				if (n_sent - base_cnt < RANDOM_ITEMS)
					send_random_unit(sb.mtu_used(), 1);
			// leave a nal open so the next setting lands inside it
			if ($urandom_range(0, 2) == 0)
				send_random_unit(sb.mtu_used(), 0);
			phase++;
		end

		byte_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: h264_rtp_packetizer_top.f
hw/rtl/h264rtp_pkg.sv
hw/rtl/h264rtp_cfg.sv
hw/rtl/h264rtp_core.sv
hw/rtl/h264rtp_outq.sv
hw/rtl/h264rtp_packetizer_top.sv
tb/h264_rtp_packetizer_top_tb.sv
